/* hw/rtl/absolute_encoder_cc_accumulator_macros.svh */
// assertion helpers, clocked on clk and switched off while arst_n is low
`ifndef ABSOLUTE_ENCODER_CC_ACCUMULATOR_MACROS_SVH
`define ABSOLUTE_ENCODER_CC_ACCUMULATOR_MACROS_SVH

// same-cycle implication
`define AECC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// next-cycle implication
`define AECC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

/* hw/rtl/aecc_pkg.sv */
`default_nettype none

package aecc_pkg;

	localparam int ENCODER_COUNT_DEF = 8;
	localparam int BANK_COUNT_DEF    = 128;

	localparam int VALUE_W = 7;
	localparam int CODE_W  = 8;
	localparam int IDX_W   = 3;

	localparam logic [CODE_W-1:0]  NO_POSITION = 8'hFF;
	localparam logic [VALUE_W-1:0] VALUE_MAX   = 7'd127;
	localparam logic [VALUE_W-1:0] WRAP_LIMIT  = 7'd100;
	localparam logic [CODE_W-1:0]  RING_SIZE   = 8'd128;
	localparam logic [VALUE_W-1:0] LED_SHIFT   = 7'd64;
	localparam logic [IDX_W-1:0]   LED_SPLIT   = 3'd4;

	typedef enum logic {
		ACT_SAMPLE = 1'b0,
		ACT_WRITE  = 1'b1
	} action_t;

	typedef struct packed {
		logic ram_we;
		logic lp_we;
	} upd_ctrl_t;

	localparam logic [CODE_W-1:0] CODE_TABLE [256] = '{
		8'hFF,8'h08,8'h18,8'h17,8'h28,8'hFF,8'h27,8'h24,8'h38,8'h39,8'hFF,8'hFF,8'h37,8'hFF,8'h34,8'h0D,
		8'h78,8'h07,8'hFF,8'h14,8'h29,8'hFF,8'hFF,8'h7D,8'hFF,8'hFF,8'hFF,8'h13,8'h36,8'hFF,8'h35,8'h12,
		8'h68,8'hFF,8'h19,8'hFF,8'hFF,8'hFF,8'h26,8'h25,8'h69,8'h3A,8'h6A,8'hFF,8'hFF,8'hFF,8'hFF,8'h0E,
		8'h77,8'h04,8'hFF,8'h6D,8'hFF,8'h03,8'hFF,8'h02,8'h76,8'hFF,8'h6B,8'h6C,8'hFF,8'hFF,8'hFF,8'h01,
		8'h48,8'hFF,8'h49,8'hFF,8'hFF,8'hFF,8'hFF,8'h23,8'h47,8'h46,8'hFF,8'hFF,8'h44,8'h45,8'h1D,8'h22,
		8'h79,8'h06,8'h4A,8'hFF,8'h7A,8'h7B,8'hFF,8'h7C,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'h1E,8'h11,
		8'hFF,8'hFF,8'h1A,8'hFF,8'hFF,8'hFF,8'h1B,8'hFF,8'hFF,8'h3B,8'hFF,8'hFF,8'h43,8'hFF,8'h1C,8'h0F,
		8'hFF,8'h05,8'hFF,8'h6E,8'hFF,8'hFF,8'hFF,8'h6F,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'h10,
		8'h58,8'h09,8'hFF,8'h16,8'h59,8'h5A,8'hFF,8'hFF,8'hFF,8'h0A,8'hFF,8'h0B,8'hFF,8'hFF,8'h33,8'h0C,
		8'hFF,8'hFF,8'hFF,8'h15,8'h2A,8'hFF,8'hFF,8'h7E,8'hFF,8'hFF,8'hFF,8'hFF,8'h2B,8'hFF,8'hFF,8'h7F,
		8'h67,8'hFF,8'hFF,8'hFF,8'h66,8'h5B,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,
		8'h74,8'h5D,8'h73,8'h72,8'hFF,8'h5C,8'hFF,8'h71,8'h75,8'h5E,8'hFF,8'h5F,8'hFF,8'hFF,8'hFF,8'h00,
		8'h57,8'hFF,8'h56,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'h54,8'hFF,8'h55,8'hFF,8'h2D,8'h2E,8'h32,8'h21,
		8'hFF,8'hFF,8'h4B,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'h53,8'hFF,8'hFF,8'hFF,8'h2C,8'hFF,8'h1F,8'h20,
		8'h64,8'h63,8'hFF,8'hFF,8'h65,8'hFF,8'hFF,8'hFF,8'h3D,8'h3C,8'h3E,8'hFF,8'h42,8'h2F,8'h31,8'h30,
		8'h4D,8'h62,8'h4C,8'h61,8'h4E,8'h4F,8'hFF,8'h70,8'h52,8'h51,8'h3F,8'h60,8'h41,8'h50,8'h40,8'hFF
	};

endpackage

`default_nettype wire

/* hw/rtl/aecc_ram.sv */
`default_nettype none

module aecc_ram #(
	parameter int WIDTH = 7,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// read returns the old word on a same-address write
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/aecc_update.sv */
`default_nettype none

module aecc_update (
	input  wire aecc_pkg::action_t                 action,
	input  wire logic [aecc_pkg::IDX_W-1:0]        enc,
	input  wire logic                              enc_ok,
	input  wire logic                              bank_ok,
	input  wire logic [aecc_pkg::CODE_W-1:0]       code,
	input  wire logic [aecc_pkg::VALUE_W-1:0]      wvalue,
	input  wire logic [aecc_pkg::VALUE_W-1:0]      prev,
	input  wire logic [aecc_pkg::VALUE_W-1:0]      cur,
	output      logic [aecc_pkg::VALUE_W-1:0]      stored,
	output      logic [aecc_pkg::VALUE_W-1:0]      led,
	output      logic [aecc_pkg::VALUE_W-1:0]      position,
	output      logic                              code_valid,
	output      aecc_pkg::upd_ctrl_t               ctrl
);

	logic [aecc_pkg::VALUE_W-1:0] code7;
	logic                         gt;
	logic                         lt;
	logic [aecc_pkg::VALUE_W-1:0] d;
	logic                         wrap;
	logic                         up;
	logic [aecc_pkg::VALUE_W-1:0] amount;
	logic [aecc_pkg::VALUE_W:0]   sum;
	logic [aecc_pkg::VALUE_W-1:0] stepped;
	logic [aecc_pkg::VALUE_W-1:0] val;
	logic [aecc_pkg::IDX_W-1:0]   grp;

	assign code7 = code[aecc_pkg::VALUE_W-1:0];
	assign gt    = code7 > prev;
	assign lt    = code7 < prev;
	assign d     = gt ? (code7 - prev) : (lt ? (prev - code7) : '0);
	assign wrap  = d > aecc_pkg::WRAP_LIMIT;
	// a long jump is the short way around the ring, in the other direction
	assign up     = gt ^ wrap;
	assign amount = wrap ? aecc_pkg::VALUE_W'(aecc_pkg::RING_SIZE - {1'b0, d}) : d;
	assign sum    = {1'b0, cur} + {1'b0, amount};

	always_comb begin
		if (up) begin
			stepped = (sum > {1'b0, aecc_pkg::VALUE_MAX}) ? aecc_pkg::VALUE_MAX
				: sum[aecc_pkg::VALUE_W-1:0];
		end else begin
			stepped = (amount > cur) ? '0 : (cur - amount);
		end
	end

	always_comb begin
		code_valid = 1'b0;
		ctrl       = '0;
		val        = '0;
		position   = '0;
		if (enc_ok) begin
			case (action)
				aecc_pkg::ACT_WRITE: begin
					position    = prev;
					ctrl.ram_we = bank_ok;
					val         = bank_ok ? wvalue : '0;
				end
				aecc_pkg::ACT_SAMPLE: begin
					code_valid  = code != aecc_pkg::NO_POSITION;
					ctrl.lp_we  = code_valid;
					ctrl.ram_we = code_valid & bank_ok;
					position    = code_valid ? code7 : prev;
					if (bank_ok) begin
						val = code_valid ? stepped : cur;
					end
				end
				default: begin
					val = '0;
				end
			endcase
		end
	end

	assign stored = val;
	assign grp    = enc - aecc_pkg::LED_SPLIT;

	always_comb begin
		if (!enc_ok) begin
			led = '0;
		end else if (enc < aecc_pkg::LED_SPLIT) begin
			led = val + aecc_pkg::LED_SHIFT;
		end else begin
			// quarter ring per encoder, value scaled down by four
			led = {grp[1:0], val[aecc_pkg::VALUE_W-1:2]};
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/absolute_encoder_cc_accumulator.sv */
// Absolute encoder accumulator.
// Input channel (in_valid/in_stall): one item per sample or direct write, with
// action, encoder_index, raw_code, write_bank and write_value as separate ports.
// Output channel (out_valid/out_stall): one result item per input item, in order,
// carrying stored_value, led_index, code_valid and position.
// Config channel (cfg_valid/cfg_ready): writes active_bank, always ready.
// Path: the accepting edge loads the input register, and the result register,
// which drives the outputs, is loaded from it once free. Throughput: one item
// per cycle while out_stall does not hold the result register and the sweep is
// done; the stored-value update is a read of the bank RAM issued at acceptance
// and a write-back as the item leaves the input register, with a forward path for back-to-back items.
// Reset: arst_n clears control state, active_bank and the per-encoder positions,
// then the bank RAM is swept to zero, one entry per cycle, over all of its entries:
// BANK_COUNT times ENCODER_COUNT, each rounded up to a power of two of at least two
// (1024 entries at the defaults); in_stall is high during the sweep.
// When out_stall holds the result register, the input register can still take
// one more item; beyond that in_stall rises.
`default_nettype none

module absolute_encoder_cc_accumulator #(
	parameter int ENCODER_COUNT = aecc_pkg::ENCODER_COUNT_DEF,
	parameter int BANK_COUNT    = aecc_pkg::BANK_COUNT_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output      logic                              in_stall,
	input  wire logic                              action,
	input  wire logic [aecc_pkg::IDX_W-1:0]        encoder_index,
	input  wire logic [aecc_pkg::CODE_W-1:0]       raw_code,
	input  wire logic [aecc_pkg::VALUE_W-1:0]      write_bank,
	input  wire logic [aecc_pkg::VALUE_W-1:0]      write_value,
	output      logic                              out_valid,
	input  wire logic                              out_stall,
	output      logic [aecc_pkg::VALUE_W-1:0]      stored_value,
	output      logic [aecc_pkg::VALUE_W-1:0]      led_index,
	output      logic                              code_valid,
	output      logic [aecc_pkg::VALUE_W-1:0]      position,
	input  wire logic                              cfg_valid,
	output      logic                              cfg_ready,
	input  wire logic [aecc_pkg::VALUE_W-1:0]      cfg_active_bank
);

`include "absolute_encoder_cc_accumulator_macros.svh"

	localparam int ENC_W  = (ENCODER_COUNT > 1) ? $clog2(ENCODER_COUNT) : 1;
	localparam int BANK_W = (BANK_COUNT > 1) ? $clog2(BANK_COUNT) : 1;
	localparam int ADDR_W = BANK_W + ENC_W;
	localparam int DEPTH  = 1 << ADDR_W;

	logic [aecc_pkg::VALUE_W-1:0] active_bank_q;
	logic                         clearing_q;
	logic [ADDR_W-1:0]            clr_addr_q;

	logic [aecc_pkg::VALUE_W-1:0] last_pos_q [ENCODER_COUNT];

	// input side
	logic                         in_accept;
	aecc_pkg::action_t            in_action;
	logic [aecc_pkg::VALUE_W-1:0] in_bank;
	logic                         in_enc_ok;
	logic                         in_bank_ok;
	logic [ADDR_W-1:0]            in_addr;

	// stage 1
	logic                         valid_s1;
	aecc_pkg::action_t            action_s1;
	logic [aecc_pkg::IDX_W-1:0]   enc_s1;
	logic                         enc_ok_s1;
	logic                         bank_ok_s1;
	logic [aecc_pkg::CODE_W-1:0]  code_s1;
	logic [aecc_pkg::VALUE_W-1:0] wvalue_s1;
	logic [ADDR_W-1:0]            addr_s1;
	logic                         fwd_v_s1;
	logic [ADDR_W-1:0]            fwd_addr_s1;
	logic [aecc_pkg::VALUE_W-1:0] fwd_data_s1;

	// stage 2 (result register)
	logic                         valid_s2;
	logic [aecc_pkg::VALUE_W-1:0] stored_s2;
	logic [aecc_pkg::VALUE_W-1:0] led_s2;
	logic                         code_valid_s2;
	logic [aecc_pkg::VALUE_W-1:0] position_s2;

	logic                         s2_free;
	logic                         s1_adv;
	logic [ENC_W-1:0]             enc_idx_s1;
	logic [aecc_pkg::VALUE_W-1:0] prev_s1;
	logic [aecc_pkg::VALUE_W-1:0] ram_rdata;
	logic [aecc_pkg::VALUE_W-1:0] cur_s1;
	logic [aecc_pkg::VALUE_W-1:0] upd_stored;
	logic [aecc_pkg::VALUE_W-1:0] upd_led;
	logic [aecc_pkg::VALUE_W-1:0] upd_position;
	logic                         upd_code_valid;
	aecc_pkg::upd_ctrl_t          upd_ctrl;
	logic                         item_we;
	logic                         ram_we;
	logic [ADDR_W-1:0]            ram_waddr;
	logic [aecc_pkg::VALUE_W-1:0] ram_wdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_bank_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			active_bank_q <= cfg_active_bank;
		end
	end

	// handshake
	assign s2_free   = !valid_s2 || !out_stall;
	assign s1_adv    = valid_s1 && s2_free;
	assign in_stall  = clearing_q || (valid_s1 && !s2_free);
	assign in_accept = in_valid && !in_stall;

	assign in_action  = aecc_pkg::action_t'(action);
	assign in_bank    = (in_action == aecc_pkg::ACT_WRITE) ? write_bank : active_bank_q;
	assign in_enc_ok  = int'(encoder_index) < ENCODER_COUNT;
	assign in_bank_ok = int'(in_bank) < BANK_COUNT;
	assign in_addr    = {BANK_W'(in_bank), ENC_W'(encoder_index)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			fwd_v_s1 <= 1'b0;
		end else begin
			if (in_accept) begin
				valid_s1 <= 1'b1;
				// a write landing on the same edge as this item's read is not in rdata
				fwd_v_s1 <= item_we;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			action_s1   <= in_action;
			enc_s1      <= encoder_index;
			enc_ok_s1   <= in_enc_ok;
			bank_ok_s1  <= in_bank_ok;
			code_s1     <= aecc_pkg::CODE_TABLE[raw_code];
			wvalue_s1   <= write_value;
			addr_s1     <= in_addr;
			fwd_addr_s1 <= addr_s1;
			fwd_data_s1 <= upd_stored;
		end
	end

	// bank value store
	assign item_we   = s1_adv && upd_ctrl.ram_we;
	assign ram_we    = clearing_q || item_we;
	assign ram_waddr = clearing_q ? clr_addr_q : addr_s1;
	assign ram_wdata = clearing_q ? '0 : upd_stored;

	aecc_ram #(
		.WIDTH (aecc_pkg::VALUE_W),
		.DEPTH (DEPTH)
	) u_bank_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (in_accept),
		.raddr (in_addr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (&clr_addr_q) begin
				clearing_q <= 1'b0;
			end
		end
	end

	assign cur_s1 = (fwd_v_s1 && (fwd_addr_s1 == addr_s1)) ? fwd_data_s1 : ram_rdata;

	assign enc_idx_s1 = ENC_W'(enc_s1);
	assign prev_s1    = last_pos_q[enc_idx_s1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ENCODER_COUNT; i++) begin
				last_pos_q[i] <= '0;
			end
		end else if (s1_adv && upd_ctrl.lp_we) begin
			last_pos_q[enc_idx_s1] <= code_s1[aecc_pkg::VALUE_W-1:0];
		end
	end

	aecc_update u_update (
		.action     (action_s1),
		.enc        (enc_s1),
		.enc_ok     (enc_ok_s1),
		.bank_ok    (bank_ok_s1),
		.code       (code_s1),
		.wvalue     (wvalue_s1),
		.prev       (prev_s1),
		.cur        (cur_s1),
		.stored     (upd_stored),
		.led        (upd_led),
		.position   (upd_position),
		.code_valid (upd_code_valid),
		.ctrl       (upd_ctrl)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			stored_s2     <= upd_stored;
			led_s2        <= upd_led;
			code_valid_s2 <= upd_code_valid;
			position_s2   <= upd_position;
		end
	end

	assign out_valid    = valid_s2;
	assign stored_value = stored_s2;
	assign led_index    = led_s2;
	assign code_valid   = code_valid_s2;
	assign position     = position_s2;

	`AECC_ASSERT_NOW(a_no_accept_in_sweep, clearing_q, !in_accept, "item accepted during ram sweep")
	`AECC_ASSERT_NOW(a_item_write_after_sweep, item_we, !clearing_q, "item write during ram sweep")
	`AECC_ASSERT_NEXT(a_s1_holds, valid_s1 && !s2_free, valid_s1, "stage 1 item lost under stall")
	`AECC_ASSERT_NEXT(a_bad_encoder_zero, s1_adv && !enc_ok_s1, (stored_value == '0) && (led_index == '0) && (position == '0) && !code_valid, "out of range encoder gave nonzero result")

endmodule

`default_nettype wire

/* tb/encoder_value_checker.sv */
module encoder_value_checker (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic       in_stall,
	input  wire logic       action,
	input  wire logic [2:0] encoder_index,
	input  wire logic [7:0] raw_code,
	input  wire logic [6:0] write_bank,
	input  wire logic [6:0] write_value,
	input  wire logic       out_valid,
	input  wire logic       out_stall,
	input  wire logic [6:0] stored_value,
	input  wire logic [6:0] led_index,
	input  wire logic       code_valid,
	input  wire logic [6:0] position,
	input  wire logic       cfg_valid,
	input  wire logic       cfg_ready,
	input  wire logic [6:0] cfg_active_bank,
	output int              mismatch_count,
	output int              results_owed
);
	import aecc_pkg::*;

	localparam int ENCODERS   = 8;
	localparam int BANKS      = 128;
	localparam int WRAP_SPAN  = 100;
	localparam int RING       = 128;
	localparam int TOP_VALUE  = 127;
	localparam int NOT_A_CODE = 255;

	typedef struct packed {
		logic [6:0] stored;
		logic [6:0] led;
		logic       valid;
		logic [6:0] pos;
	} encoder_result_t;

	// absolute position for each raw pin pattern, 0xFF where the pattern is illegal
	localparam logic [7:0] POS_OF_CODE [256] = '{
		8'hFF,8'h08,8'h18,8'h17,8'h28,8'hFF,8'h27,8'h24,8'h38,8'h39,8'hFF,8'hFF,8'h37,8'hFF,8'h34,8'h0D,
		8'h78,8'h07,8'hFF,8'h14,8'h29,8'hFF,8'hFF,8'h7D,8'hFF,8'hFF,8'hFF,8'h13,8'h36,8'hFF,8'h35,8'h12,
		8'h68,8'hFF,8'h19,8'hFF,8'hFF,8'hFF,8'h26,8'h25,8'h69,8'h3A,8'h6A,8'hFF,8'hFF,8'hFF,8'hFF,8'h0E,
		8'h77,8'h04,8'hFF,8'h6D,8'hFF,8'h03,8'hFF,8'h02,8'h76,8'hFF,8'h6B,8'h6C,8'hFF,8'hFF,8'hFF,8'h01,
		8'h48,8'hFF,8'h49,8'hFF,8'hFF,8'hFF,8'hFF,8'h23,8'h47,8'h46,8'hFF,8'hFF,8'h44,8'h45,8'h1D,8'h22,
		8'h79,8'h06,8'h4A,8'hFF,8'h7A,8'h7B,8'hFF,8'h7C,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'h1E,8'h11,
		8'hFF,8'hFF,8'h1A,8'hFF,8'hFF,8'hFF,8'h1B,8'hFF,8'hFF,8'h3B,8'hFF,8'hFF,8'h43,8'hFF,8'h1C,8'h0F,
		8'hFF,8'h05,8'hFF,8'h6E,8'hFF,8'hFF,8'hFF,8'h6F,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'h10,
		8'h58,8'h09,8'hFF,8'h16,8'h59,8'h5A,8'hFF,8'hFF,8'hFF,8'h0A,8'hFF,8'h0B,8'hFF,8'hFF,8'h33,8'h0C,
		8'hFF,8'hFF,8'hFF,8'h15,8'h2A,8'hFF,8'hFF,8'h7E,8'hFF,8'hFF,8'hFF,8'hFF,8'h2B,8'hFF,8'hFF,8'h7F,
		8'h67,8'hFF,8'hFF,8'hFF,8'h66,8'h5B,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,
		8'h74,8'h5D,8'h73,8'h72,8'hFF,8'h5C,8'hFF,8'h71,8'h75,8'h5E,8'hFF,8'h5F,8'hFF,8'hFF,8'hFF,8'h00,
		8'h57,8'hFF,8'h56,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'h54,8'hFF,8'h55,8'hFF,8'h2D,8'h2E,8'h32,8'h21,
		8'hFF,8'hFF,8'h4B,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'h53,8'hFF,8'hFF,8'hFF,8'h2C,8'hFF,8'h1F,8'h20,
		8'h64,8'h63,8'hFF,8'hFF,8'h65,8'hFF,8'hFF,8'hFF,8'h3D,8'h3C,8'h3E,8'hFF,8'h42,8'h2F,8'h31,8'h30,
		8'h4D,8'h62,8'h4C,8'h61,8'h4E,8'h4F,8'hFF,8'h70,8'h52,8'h51,8'h3F,8'h60,8'h41,8'h50,8'h40,8'hFF
	};

	logic [6:0]      bank_copy;
	logic [6:0]      held_pos [ENCODERS];
	logic [6:0]      value_store [BANKS][ENCODERS];
	encoder_result_t owed_q [$];

	function automatic encoder_result_t advance_encoder(action_t act, logic [2:0] enc,
			logic [7:0] raw, logic [6:0] wbank, logic [6:0] wvalue);
		int              bank;
		int              code;
		int              moved;
		int              val;
		encoder_result_t r;
		r = '0;
		if (int'(enc) >= ENCODERS)
			return r;
		if (act == ACT_WRITE) begin
			bank = wbank;
			if (bank < BANKS) begin
				value_store[bank][enc] = wvalue;
				r.stored = wvalue;
			end
		end else begin
			code = POS_OF_CODE[raw];
			bank = bank_copy;
			if (code != NOT_A_CODE) begin
				r.valid = 1'b1;
				if (bank < BANKS) begin
					moved = code - int'(held_pos[enc]);
					// a jump of more than the wrap span is the short way round the ring
					if (moved > WRAP_SPAN)
						moved = moved - RING;
					else if (moved < -WRAP_SPAN)
						moved = moved + RING;
					val = int'(value_store[bank][enc]) + moved;
					if (val > TOP_VALUE)
						val = TOP_VALUE;
					else if (val < 0)
						val = 0;
					value_store[bank][enc] = 7'(val);
				end
				held_pos[enc] = 7'(code);
			end
			if (bank < BANKS)
				r.stored = value_store[bank][enc];
		end
		r.pos = held_pos[enc];
		if (enc < 3'd4)
			r.led = r.stored + 7'd64;
		else
			r.led = 7'(32 * (int'(enc) - 4) + int'(r.stored) / 4);
		return r;
	endfunction

	function automatic void compare_field(string name, logic [6:0] want, logic [6:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		encoder_result_t want;
		if (!arst_n) begin
			bank_copy = '0;
			foreach (held_pos[e])
				held_pos[e] = '0;
			foreach (value_store[b, e])
				value_store[b][e] = '0;
			owed_q.delete();
			mismatch_count = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (owed_q.size() == 0) begin
					$error("result item with no item waiting for it");
					mismatch_count++;
				end else begin
					want = owed_q.pop_front();
					compare_field("stored_value", want.stored, stored_value);
					compare_field("led_index", want.led, led_index);
					compare_field("code_valid", 7'(want.valid), 7'(code_valid));
					compare_field("position", want.pos, position);
				end
			end
			if (cfg_valid && cfg_ready)
				bank_copy = cfg_active_bank;
			if (in_valid && !in_stall)
				owed_q.push_back(advance_encoder(action_t'(action), encoder_index, raw_code,
					write_bank, write_value));
		end
		results_owed = owed_q.size();
	end

endmodule

/* tb/tb.sv */
module tb;
	import aecc_pkg::*;

	localparam int STALL_LIMIT = 5000;
	localparam int PHASE_ITEMS = 170;
	localparam int HOLD_CYCLES = 300;

	logic                clk             = 1'b0;
	logic                arst_n          = 1'b0;
	logic                in_valid        = 1'b0;
	logic                in_stall;
	logic                action          = ACT_SAMPLE;
	logic [IDX_W-1:0]    encoder_index   = '0;
	logic [CODE_W-1:0]   raw_code        = '0;
	logic [VALUE_W-1:0]  write_bank      = '0;
	logic [VALUE_W-1:0]  write_value     = '0;
	logic                out_valid;
	logic                out_stall       = 1'b0;
	logic [VALUE_W-1:0]  stored_value;
	logic [VALUE_W-1:0]  led_index;
	logic                code_valid;
	logic [VALUE_W-1:0]  position;
	logic                cfg_valid       = 1'b0;
	logic                cfg_ready;
	logic [VALUE_W-1:0]  cfg_active_bank = '0;

	bit                  calm            = 1'b0;
	bit                  hold_off_req    = 1'b0;
	logic [CODE_W-1:0]   code_for_pos [128];
	logic [VALUE_W-1:0]  walk_pos [8];
	int                  fail_count;
	int                  owed_count;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	absolute_encoder_cc_accumulator dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.action          (action),
		.encoder_index   (encoder_index),
		.raw_code        (raw_code),
		.write_bank      (write_bank),
		.write_value     (write_value),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.stored_value    (stored_value),
		.led_index       (led_index),
		.code_valid      (code_valid),
		.position        (position),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_active_bank (cfg_active_bank)
	);

	encoder_value_checker value_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.action          (action),
		.encoder_index   (encoder_index),
		.raw_code        (raw_code),
		.write_bank      (write_bank),
		.write_value     (write_value),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.stored_value    (stored_value),
		.led_index       (led_index),
		.code_valid      (code_valid),
		.position        (position),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_active_bank (cfg_active_bank),
		.mismatch_count  (fail_count),
		.results_owed    (owed_count)
	);

	task automatic idle_gap();
		int n;
		int pick;
		pick = $urandom_range(0, 19);
		if (calm || pick < 11)
			n = 0;
		else if (pick < 18)
			n = $urandom_range(1, 3);
		else
			n = $urandom_range(8, 30);
		if (n > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	task automatic offer_item(action_t act, logic [2:0] enc, logic [7:0] raw,
			logic [6:0] wbank, logic [6:0] wvalue);
		@(negedge clk);
		action        <= act;
		encoder_index <= enc;
		raw_code      <= raw;
		write_bank    <= wbank;
		write_value   <= wvalue;
		in_valid      <= 1'b1;
		do @(posedge clk); while (in_stall);
		// keep the walk in step with what the encoder now holds
		if (act == ACT_SAMPLE && CODE_TABLE[raw] != NO_POSITION)
			walk_pos[enc] = CODE_TABLE[raw][6:0];
		idle_gap();
	endtask

	task automatic offer_sample(logic [2:0] enc, logic [7:0] raw);
		offer_item(ACT_SAMPLE, enc, raw, 7'($urandom), 7'($urandom));
	endtask

	task automatic offer_write(logic [2:0] enc, logic [6:0] bank, logic [6:0] value);
		offer_item(ACT_WRITE, enc, 8'($urandom), bank, value);
	endtask

	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		wait (owed_count == 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_active_bank(logic [6:0] bank);
		@(negedge clk);
		cfg_valid       <= 1'b1;
		cfg_active_bank <= bank;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_item(logic [6:0] bank_now);
		int         pick;
		int         step;
		logic [2:0] enc;
		logic [6:0] target;
		logic [6:0] value;
		pick = $urandom_range(0, 99);
		enc  = 3'($urandom_range(0, 7));
		if (pick < 68) begin
			// mostly a turning knob: small moves, some larger, a few that wrap
			step = $urandom_range(0, 19);
			if (step < 12)
				step = $urandom_range(0, 8) - 4;
			else if (step < 17)
				step = $urandom_range(0, 60) - 30;
			else
				step = $urandom_range(0, 127);
			target = walk_pos[enc] + 7'(step);
			offer_sample(enc, code_for_pos[target]);
		end else if (pick < 82) begin
			offer_sample(enc, 8'($urandom_range(0, 255)));
		end else begin
			step = $urandom_range(0, 9);
			if (step < 2)
				value = 7'd0;
			else if (step < 4)
				value = 7'd127;
			else
				value = 7'($urandom);
			offer_write(enc, ($urandom_range(0, 2) != 0) ? bank_now : 7'($urandom), value);
		end
	endtask

	// receiver: alternating flow and stall stretches, plus one long hold-off on request
	initial begin : receiver
		int run_left;
		int hold_left;
		bit stalling;
		run_left  = 0;
		hold_left = 0;
		stalling  = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				hold_left    = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				if (run_left == 0) begin
					if (calm) begin
						stalling = 1'b0;
						run_left = 1;
					end else begin
						stalling = !stalling;
						if (stalling)
							run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
								: $urandom_range(1, 3);
						else
							run_left = $urandom_range(1, 15);
					end
				end
				run_left--;
				out_stall <= stalling;
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("tb NOT OK");
		$finish;
	end

	initial begin : stimulus
		logic [6:0] phase_banks [7];
		foreach (code_for_pos[p])
			code_for_pos[p] = '0;
		for (int c = 0; c < 256; c++)
			if (CODE_TABLE[c] != NO_POSITION)
				code_for_pos[CODE_TABLE[c][6:0]] = 8'(c);
		foreach (walk_pos[e])
			walk_pos[e] = '0;
		phase_banks = '{7'd127, 7'd0, 7'd0, 7'd1, 7'd126, 7'd0, 7'd64};
		phase_banks[2] = 7'($urandom);
		phase_banks[5] = 7'($urandom);

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		set_active_bank(7'd0);

		// one knob through the ring edges, saturation and illegal codes
		offer_sample(3'd0, 8'h00);
		offer_sample(3'd0, 8'hBF);
		offer_sample(3'd0, 8'h9F);
		offer_sample(3'd0, 8'hBF);
		offer_sample(3'd0, 8'hE0);
		offer_sample(3'd0, 8'h9F);
		offer_sample(3'd0, 8'hFF);
		offer_sample(3'd0, 8'hE4);
		offer_sample(3'd0, 8'hBF);
		// direct writes across encoders and bank extremes
		offer_write(3'd7, 7'd127, 7'd127);
		offer_write(3'd4, 7'd0, 7'd0);
		offer_write(3'd3, 7'd0, 7'd127);
		offer_write(3'd5, 7'd0, 7'd127);
		offer_write(3'd6, 7'd0, 7'd0);
		offer_sample(3'd7, 8'h01);
		offer_sample(3'd4, 8'hEF);
		offer_sample(3'd6, 8'h9F);
		offer_write(3'd1, 7'd0, 7'd5);
		offer_sample(3'd1, 8'h9F);
		offer_sample(3'd2, 8'hBF);
		offer_write(3'd0, 7'd0, 7'd0);
		offer_sample(3'd5, 8'h00);

		foreach (phase_banks[p]) begin
			settle();
			set_active_bank(phase_banks[p]);
			calm = (p == 3);
			if (p == 1)
				hold_off_req = 1'b1;
			repeat (PHASE_ITEMS) random_item(phase_banks[p]);
		end
		calm = 1'b0;
		settle();
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule
